// ----- src/bmpb_pkg.sv -----
// Shared constants, types and arithmetic helpers for the brush mask pixel blender.
package bmpb_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int LEVEL_W = 8;
  localparam int DIM_W = 7;

  localparam logic [1:0] ACT_WRITE    = 2'd0;
  localparam logic [1:0] ACT_SHADE    = 2'd1;
  localparam logic [1:0] ACT_OPACITY  = 2'd2;
  localparam logic [1:0] ACT_TWO_TONE = 2'd3;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // One write request toward the mask store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [LEVEL_W-1:0] data;
  } mask_wr_t;

  // Truncating divide by 255 for values up to 255*255.
  function automatic logic [7:0] div255(input logic [15:0] val);
    logic [16:0] t;
    t = {1'b0, val} + {9'd0, val[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

// ----- src/bmpb_mask_mem.sv -----
// Mask store: single-port-write, registered-read memory with a clearing pass after reset.
module bmpb_mask_mem
  import bmpb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  mask_wr_t           wr,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [LEVEL_W-1:0] rd_data,
  output logic               clearing
);

  logic [LEVEL_W-1:0] mem [STORE_DEPTH];
  logic [ADDR_W:0]    clr_cnt;

  assign clearing = (clr_cnt != (ADDR_W+1)'(STORE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt[ADDR_W-1:0]] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- src/brush_mask_pixel_blender.sv -----
// Top level of the brush mask pixel blender: mask addressing, blend pipeline and outputs.
//
// Usage. An item is taken at a clock edge where start is high and busy is low.
// The action field picks the operation: a mask write stores level at
// (pos_x, pos_y) when that point lies inside the brush and yields no result;
// shade, opacity and two-tone renders read the mask level there (zero outside
// the brush) and combine the colors with it.
// Each render beat appears on the result ports for exactly one cycle, marked
// by done; it passes through stage 1, stage 2 and the output registers.
// While busy is low the block takes one item per cycle; a write and a
// following read of the same entry never overlap, because the write lands on
// the acceptance edge and the read of a later item is issued at that item's
// own acceptance edge, so it sees the written level and no forwarding is needed.
// The receiver cannot stall: results are simply presented and taken.
// Reset (rst, synchronous) sets both brush dimensions to 64 and starts a
// clearing pass that zeroes the mask one entry per cycle over all 4096 entries;
// busy stays high for its duration and no item is accepted. Configuration
// writes (cfg_we, cfg_index, cfg_data) take effect at once, also during it.
module brush_mask_pixel_blender
  import bmpb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [DIM_W-1:0]   cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic signed [7:0]  pos_x,
  input  logic signed [7:0]  pos_y,
  input  logic [7:0]         level,
  input  logic [7:0]         color_a_red,
  input  logic [7:0]         color_a_green,
  input  logic [7:0]         color_a_blue,
  input  logic [7:0]         color_a_alpha,
  input  logic [7:0]         color_b_red,
  input  logic [7:0]         color_b_green,
  input  logic [7:0]         color_b_blue,
  input  logic [7:0]         color_b_alpha,
  output logic               done,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic [7:0]         out_alpha,
  output logic [7:0]         mask_level
);

  localparam logic [DIM_W-1:0] MAX_W = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H = DIM_W'(MAX_HEIGHT);

  // Configuration registers.
  logic [DIM_W-1:0] brush_width;
  logic [DIM_W-1:0] brush_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      brush_width  <= DIM_W'(64);
      brush_height <= DIM_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  brush_width  <= cfg_data;
        CFG_HEIGHT: brush_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Address generation for the incoming item.
  logic [DIM_W-1:0]   w_eff;
  logic [DIM_W-1:0]   h_eff;
  logic               in_brush;
  logic [2*DIM_W-1:0] row_base;
  logic [2*DIM_W:0]   addr_full;
  logic [ADDR_W-1:0]  addr;
  logic               accept;
  mask_wr_t           wr;
  logic [LEVEL_W-1:0] rd_data;
  logic               clearing;

  assign w_eff = (brush_width > MAX_W) ? MAX_W : brush_width;
  assign h_eff = (brush_height > MAX_H) ? MAX_H : brush_height;
  assign in_brush = !pos_x[7] && !pos_y[7] &&
                    (pos_x[6:0] < w_eff) && (pos_y[6:0] < h_eff);
  assign row_base = w_eff * pos_y[6:0];
  assign addr_full = {1'b0, row_base} + {8'd0, pos_x[6:0]};
  assign addr = addr_full[ADDR_W-1:0];

  assign busy   = clearing;
  assign accept = start && !busy;

  assign wr.en   = accept && (action == ACT_WRITE) && in_brush;
  assign wr.addr = addr;
  assign wr.data = level;

  bmpb_mask_mem u_mask_mem (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd_addr  (addr),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  // Stage 1: item waits for the mask read data. Lane 3 is alpha.
  logic       s1_valid;
  logic [1:0] s1_act;
  logic       s1_inside;
  logic [7:0] s1_a [4];
  logic [7:0] s1_b [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && (action != ACT_WRITE);
    end
    s1_act    <= action;
    s1_inside <= in_brush;
    s1_a[0] <= color_a_red;
    s1_a[1] <= color_a_green;
    s1_a[2] <= color_a_blue;
    s1_a[3] <= color_a_alpha;
    s1_b[0] <= color_b_red;
    s1_b[1] <= color_b_green;
    s1_b[2] <= color_b_blue;
    s1_b[3] <= color_b_alpha;
  end

  // Products per lane: m times the selected a operand, plus (255-m)*b for two-tone.
  logic [7:0]  m1;
  logic [7:0]  sel_a [4];
  logic [15:0] prod  [4];

  assign m1 = s1_inside ? rd_data : 8'd0;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sel_a[i] = s1_a[i];
      if (s1_act == ACT_SHADE) begin
        sel_a[i] = 8'd255 - s1_a[i];
      end
      if (i == 3) begin
        // Opacity alpha scale: a*255/256 is a-1 for nonzero a.
        sel_a[i] = (s1_a[3] == 8'd0) ? 8'd0 : s1_a[3] - 8'd1;
      end
      prod[i] = m1 * sel_a[i];
      if (s1_act == ACT_TWO_TONE) begin
        prod[i] = prod[i] + (8'd255 - m1) * s1_b[i];
      end
    end
  end

  // Stage 2: registered products, then divide and select.
  logic        s2_valid;
  logic [1:0]  s2_act;
  logic [7:0]  s2_m;
  logic [15:0] s2_prod [4];
  logic [7:0]  s2_a [4];
  logic [7:0]  s2_b [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_act <= s1_act;
    s2_m   <= m1;
    for (int i = 0; i < 4; i++) begin
      s2_prod[i] <= prod[i];
      s2_a[i]    <= s1_a[i];
      s2_b[i]    <= s1_b[i];
    end
  end

  logic [7:0] quo [4];
  logic [7:0] res [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      quo[i] = div255(s2_prod[i]);
    end
    for (int i = 0; i < 3; i++) begin
      case (s2_act)
        ACT_SHADE:    res[i] = (quo[i] > s2_b[i]) ? 8'd0 : s2_b[i] - quo[i];
        ACT_OPACITY:  res[i] = s2_a[i];
        ACT_TWO_TONE: res[i] = quo[i];
        default:      res[i] = 8'd0;
      endcase
    end
    case (s2_act)
      ACT_SHADE:    res[3] = s2_b[3];
      ACT_OPACITY:  res[3] = quo[3];
      ACT_TWO_TONE: res[3] = 8'd255;
      default:      res[3] = 8'd0;
    endcase
  end

  // Output registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid;
    end
    out_red    <= res[0];
    out_green  <= res[1];
    out_blue   <= res[2];
    out_alpha  <= res[3];
    mask_level <= s2_m;
  end

`ifndef ASSERT_OFF
  a_s1_to_s2: assert property (@(posedge clk) disable iff (rst) s1_valid |=> s2_valid)
    else $error("render beat lost between stage 1 and stage 2");
  a_s2_to_done: assert property (@(posedge clk) disable iff (rst) s2_valid |=> done)
    else $error("render beat lost before the result strobe");
  a_clear_once: assert property (@(posedge clk) disable iff (rst) !busy |=> !busy)
    else $error("clearing pass restarted without reset");
  a_no_write_clear: assert property (@(posedge clk) disable iff (rst) busy |-> !wr.en)
    else $error("mask write issued during the clearing pass");
`endif

endmodule
